[hdl/netrw_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// netrw_pkg: shared types and constants
// Event kinds, channel numbers, chip codes, register indexes, the write-list
// type that travels from the front to the back, and the period table inputs.
// ----------------------------------------------------------------------------
package netrw_pkg;

    // Event kinds.
    typedef enum logic [2:0] {
        K_ON     = 3'd0,
        K_OFF    = 3'd1,
        K_CHANGE = 3'd2,
        K_PITCH  = 3'd3,
        K_VOLUME = 3'd4,
        K_DUTY   = 3'd5
    } t_kind;

    // Target chips.
    typedef enum logic [1:0] {
        CHIP_BASE   = 2'd0,
        CHIP_PULSAW = 2'd1,
        CHIP_SQUARE = 2'd2,
        CHIP_TONE   = 2'd3
    } t_chip;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_BASE_DUTY  = 3'd0,
        REG_SWEEP      = 3'd1,
        REG_NOISE_MODE = 3'd2,
        REG_EXP_DUTY   = 3'd3,
        REG_SQ_DUTY    = 3'd4
    } t_reg;

    // Channel numbers.
    localparam logic [3:0] CH_PULSE0  = 4'd0;
    localparam logic [3:0] CH_PULSE1  = 4'd1;
    localparam logic [3:0] CH_TRI     = 4'd2;
    localparam logic [3:0] CH_NOISE   = 4'd3;
    localparam logic [3:0] CH_SAMPLE  = 4'd4;
    localparam logic [3:0] CH_EPULSE0 = 4'd5;
    localparam logic [3:0] CH_EPULSE1 = 4'd6;
    localparam logic [3:0] CH_SAW     = 4'd7;
    localparam logic [3:0] CH_SQ0     = 4'd8;
    localparam logic [3:0] CH_SQ1     = 4'd9;
    localparam logic [3:0] CH_TONEA   = 4'd10;
    localparam logic [3:0] CH_TONEB   = 4'd11;
    localparam logic [3:0] CH_TONEC   = 4'd12;
    localparam int         NUM_CH     = 13;

    localparam logic [7:0] NO_NOTE    = 8'h80;
    localparam logic [5:0] MASK_RESET = 6'h3F;
    localparam int         MAX_WR     = 8;
    localparam int         QUEUE_DEPTH = 2;

    // Tone generator register numbers.
    localparam logic [7:0] PSG_MIXER = 8'd7;
    localparam logic [7:0] PSG_VOL   = 8'd8;

    // Period table inputs: the base clock scaled by ten, the tone clock unscaled, and denominators in 1e-11 units.
    localparam longint unsigned BASE_CLK  = 64'd17897727;
    localparam longint unsigned TONE_CLK  = 64'd1789772;
    localparam longint unsigned PULSE_DEN = 64'd7040000000000000;
    localparam longint unsigned TRI_DEN   = 64'd14080000000000000;
    localparam longint unsigned TONE_DEN  = 64'd1408000000000000;

    // One register write.
    typedef struct packed {
        logic [1:0]  chip;
        logic [15:0] addr;
        logic [7:0]  data;
    } t_wr;

    // The ordered writes of one event.
    typedef struct packed {
        t_wr [MAX_WR-1:0] w;
        logic [3:0]       cnt;
    } t_list;

    // Equal-tempered semitone ratio 2^(s/12) in units of 1e-11.
    function automatic longint unsigned f_ratio(input int s);
        longint unsigned r;
        case (s)
            0:       r = 64'd100000000000;
            1:       r = 64'd105946309436;
            2:       r = 64'd112246204831;
            3:       r = 64'd118920711500;
            4:       r = 64'd125992104989;
            5:       r = 64'd133483985417;
            6:       r = 64'd141421356237;
            7:       r = 64'd149830707688;
            8:       r = 64'd158740105197;
            9:       r = 64'd168179283051;
            10:      r = 64'd178179743628;
            11:      r = 64'd188774862536;
            default: r = 64'd100000000000;
        endcase
        return r;
    endfunction

    // Build one write.
    function automatic t_wr f_wr(input t_chip chip, input logic [15:0] addr,
                                 input logic [7:0] data);
        t_wr w;
        w.chip = chip;
        w.addr = addr;
        w.data = data;
        return w;
    endfunction

endpackage
`default_nettype wire

[hdl/netrw_evt_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// netrw_evt_if: event channel
// Valid/ready channel carrying one note or macro event per beat.
// ----------------------------------------------------------------------------
interface netrw_evt_if;
    logic               valid;
    logic               ready;
    logic [2:0]         kind;
    logic [3:0]         channel;
    logic [6:0]         note;
    logic [8:0]         velocity;
    logic signed [12:0] period_offset;
    logic [7:0]         macro_value;

    modport source (output valid, kind, channel, note, velocity, period_offset,
                    macro_value, input ready);
    modport sink (input valid, kind, channel, note, velocity, period_offset,
                  macro_value, output ready);
endinterface
`default_nettype wire

[hdl/netrw_wr_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// netrw_wr_if: register write channel
// Valid/ready channel carrying one tagged register write per beat.
// ----------------------------------------------------------------------------
interface netrw_wr_if;
    logic        valid;
    logic        ready;
    logic [1:0]  target_chip;
    logic [15:0] address;
    logic [7:0]  data;
    logic        last;

    modport source (output valid, target_chip, address, data, last, input ready);
    modport sink (input valid, target_chip, address, data, last, output ready);
endinterface
`default_nettype wire

[hdl/netrw_cfg_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// netrw_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data per beat.
// ----------------------------------------------------------------------------
interface netrw_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[hdl/netrw_period_rom.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// netrw_period_rom: note period tables
// Pulse, triangle and tone periods per note, computed at elaboration from the
// equal-tempered formula with note 69 at 440 Hz.
// ----------------------------------------------------------------------------
module netrw_period_rom (
    input  wire logic [6:0]  i_note,
    output logic      [11:0] o_pulse,
    output logic      [11:0] o_tri,
    output logic      [11:0] o_tone
);

    logic [11:0] pulse_tab [128];
    logic [11:0] tri_tab   [128];
    logic [11:0] tone_tab  [128];

    // Build each entry from octave and semitone of its distance to note 69.
    for (genvar n = 0; n < 128; n++) begin : g_rom
        localparam int D = 69 - n;
        localparam int O = (D + 60) / 12 - 5;
        localparam int S = D - 12 * O;
        localparam longint unsigned R = netrw_pkg::f_ratio(S);
        localparam longint unsigned PD = (O >= 0) ? (netrw_pkg::PULSE_DEN >> O)
                                                  : (netrw_pkg::PULSE_DEN << (-O));
        localparam longint unsigned TD = (O >= 0) ? (netrw_pkg::TRI_DEN >> O)
                                                  : (netrw_pkg::TRI_DEN << (-O));
        localparam longint unsigned GD = (O >= 0) ? (netrw_pkg::TONE_DEN >> O)
                                                  : (netrw_pkg::TONE_DEN << (-O));
        localparam longint unsigned PQ = (netrw_pkg::BASE_CLK * R) / PD;
        localparam longint unsigned TQ = (netrw_pkg::BASE_CLK * R) / TD;
        localparam longint unsigned GQ = (netrw_pkg::TONE_CLK * R) / GD;
        localparam longint unsigned PM = (PQ != 0) ? PQ - 1 : 0;
        localparam longint unsigned TM = (TQ != 0) ? TQ - 1 : 0;
        localparam longint unsigned GM = (GQ < 1) ? 1 : GQ;
        localparam logic [11:0] PV = (PM > 4095) ? 12'd4095 : 12'(PM);
        localparam logic [11:0] TV = (TM > 2047) ? 12'd2047 : 12'(TM);
        localparam logic [11:0] GV = (GM > 4095) ? 12'd4095 : 12'(GM);
        assign pulse_tab[n] = PV;
        assign tri_tab[n]   = TV;
        assign tone_tab[n]  = GV;
    end

    // Table lookup.
    assign o_pulse = pulse_tab[i_note];
    assign o_tri   = tri_tab[i_note];
    assign o_tone  = tone_tab[i_note];

endmodule
`default_nettype wire

[hdl/netrw_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// netrw_front: event classifier
// Accepts events and configuration writes, keeps channel state and turns each
// event into its ordered list of register writes for the queue.
// ----------------------------------------------------------------------------
module netrw_front (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    netrw_evt_if.sink        i_evt,
    netrw_cfg_if.sink        i_cfg,
    input  wire logic        i_q_full,
    output logic             o_push,
    output netrw_pkg::t_list o_list
);

    logic [3:0]  r_base_duty;
    logic [15:0] r_sweep;
    logic        r_noise_mode;
    logic [5:0]  r_exp_duty;
    logic [3:0]  r_sq_duty;
    logic [7:0]  r_notes [netrw_pkg::NUM_CH];
    logic [5:0]  r_mask;

    logic        accept;
    logic        ch_ok;
    logic [7:0]  cur_note;
    logic [6:0]  rom_note;
    logic [11:0] rom_pulse, rom_tri, rom_tone;
    logic [11:0] base_per, per;
    logic [8:0]  vel;
    logic [12:0] vol_prod;
    logic [14:0] saw_prod;
    logic [3:0]  vol;
    logic [5:0]  saw_rate;
    logic [3:0]  mvol;
    logic signed [13:0] adj;
    logic [11:0] adj_c;
    logic        wide;
    logic [1:0]  tidx;
    logic [5:0]  n_mask_on, n_mask_off;
    logic [1:0]  duty;
    logic [7:0]  duty_byte;
    netrw_pkg::t_list lst;

    // Saw rate for macro volume: floor(14 * v / 5).
    function automatic logic [5:0] f_saw(input logic [3:0] v);
        logic [5:0] r;
        case (v)
            4'd0:    r = 6'd0;
            4'd1:    r = 6'd2;
            4'd2:    r = 6'd5;
            4'd3:    r = 6'd8;
            4'd4:    r = 6'd11;
            4'd5:    r = 6'd14;
            4'd6:    r = 6'd16;
            4'd7:    r = 6'd19;
            4'd8:    r = 6'd22;
            4'd9:    r = 6'd25;
            4'd10:   r = 6'd28;
            4'd11:   r = 6'd30;
            4'd12:   r = 6'd33;
            4'd13:   r = 6'd36;
            4'd14:   r = 6'd39;
            default: r = 6'd42;
        endcase
        return r;
    endfunction

    // Period register writes shared by note change, pitch offset and tone note on.
    function automatic netrw_pkg::t_list f_period(input logic [3:0] ch,
                                                  input logic [11:0] p);
        netrw_pkg::t_list l;
        logic [7:0] rg;
        l = '0;
        rg = {3'd0, (ch - netrw_pkg::CH_TONEA), 1'b0};
        case (ch)
            netrw_pkg::CH_PULSE0, netrw_pkg::CH_PULSE1, netrw_pkg::CH_TRI: begin
                l.w[0] = netrw_pkg::f_wr(netrw_pkg::CHIP_BASE,
                                         16'h4002 + {12'd0, ch[1:0], 2'd0}, p[7:0]);
                l.w[1] = netrw_pkg::f_wr(netrw_pkg::CHIP_BASE,
                                         16'h4003 + {12'd0, ch[1:0], 2'd0},
                                         {5'd0, p[10:8]});
                l.cnt = 4'd2;
            end
            netrw_pkg::CH_EPULSE0, netrw_pkg::CH_EPULSE1, netrw_pkg::CH_SAW: begin
                l.w[0] = netrw_pkg::f_wr(netrw_pkg::CHIP_PULSAW,
                                         {ch - 4'd5 + 4'h9, 12'h001}, p[7:0]);
                l.w[1] = netrw_pkg::f_wr(netrw_pkg::CHIP_PULSAW,
                                         {ch - 4'd5 + 4'h9, 12'h002},
                                         {4'h8, p[11:8]});
                l.cnt = 4'd2;
            end
            netrw_pkg::CH_SQ0, netrw_pkg::CH_SQ1: begin
                l.w[0] = netrw_pkg::f_wr(netrw_pkg::CHIP_SQUARE,
                                         {13'h0A00, ch[0], 2'b10}, p[7:0]);
                l.w[1] = netrw_pkg::f_wr(netrw_pkg::CHIP_SQUARE,
                                         {13'h0A00, ch[0], 2'b11}, {5'd0, p[10:8]});
                l.cnt = 4'd2;
            end
            netrw_pkg::CH_TONEA, netrw_pkg::CH_TONEB, netrw_pkg::CH_TONEC: begin
                l.w[0] = netrw_pkg::f_wr(netrw_pkg::CHIP_TONE, 16'hC000, rg);
                l.w[1] = netrw_pkg::f_wr(netrw_pkg::CHIP_TONE, 16'hE000, p[7:0]);
                l.w[2] = netrw_pkg::f_wr(netrw_pkg::CHIP_TONE, 16'hC000, rg | 8'd1);
                l.w[3] = netrw_pkg::f_wr(netrw_pkg::CHIP_TONE, 16'hE000,
                                         {4'd0, p[11:8]});
                l.cnt = 4'd4;
            end
            default: l.cnt = 4'd0;
        endcase
        return l;
    endfunction

    netrw_period_rom u_rom (
        .i_note  (rom_note),
        .o_pulse (rom_pulse),
        .o_tri   (rom_tri),
        .o_tone  (rom_tone)
    );

    // Handshakes: events wait for queue room, configuration is always taken.
    assign i_evt.ready = !i_q_full;
    assign i_cfg.ready = 1'b1;
    assign accept      = i_evt.valid && !i_q_full;
    assign ch_ok       = i_evt.channel < 4'(netrw_pkg::NUM_CH);
    assign cur_note    = ch_ok ? r_notes[i_evt.channel] : netrw_pkg::NO_NOTE;
    assign rom_note    = (netrw_pkg::t_kind'(i_evt.kind) == netrw_pkg::K_PITCH)
                         ? cur_note[6:0] : i_evt.note;

    // Periods, levels and clamped pitch offset.
    always_comb begin
        if (i_evt.channel == netrw_pkg::CH_TRI) begin
            base_per = rom_tri;
        end else if (i_evt.channel >= netrw_pkg::CH_EPULSE0 &&
                     i_evt.channel <= netrw_pkg::CH_SAW) begin
            base_per = rom_pulse;
        end else begin
            base_per = (rom_pulse > 12'h7FF) ? 12'h7FF : rom_pulse;
        end
        per      = (i_evt.channel >= netrw_pkg::CH_TONEA) ? rom_tone : base_per;
        vel      = (i_evt.velocity > 9'd256) ? 9'd256 : i_evt.velocity;
        vol_prod = {4'd0, vel} * 13'd15;
        saw_prod = {6'd0, vel} * 15'd42;
        vol      = vol_prod[11:8];
        saw_rate = saw_prod[13:8];
        mvol     = (i_evt.macro_value > 8'd15) ? 4'd15 : i_evt.macro_value[3:0];
        wide     = (i_evt.channel >= netrw_pkg::CH_EPULSE0 &&
                    i_evt.channel <= netrw_pkg::CH_SAW) ||
                   i_evt.channel >= netrw_pkg::CH_TONEA;
        adj      = $signed({2'b00, per}) + 14'(i_evt.period_offset);
        if (adj < 0) begin
            adj_c = 12'd0;
        end else if (wide && adj > 14'sh0FFF) begin
            adj_c = 12'hFFF;
        end else if (!wide && adj > 14'sh07FF) begin
            adj_c = 12'h7FF;
        end else begin
            adj_c = adj[11:0];
        end
        tidx       = 2'(i_evt.channel - netrw_pkg::CH_TONEA);
        n_mask_on  = r_mask & ~(6'd1 << tidx);
        n_mask_off = r_mask | (6'd1 << tidx);
        duty       = i_evt.macro_value[1:0];
        duty_byte  = {duty, 2'b11, 4'hF};
    end

    // Write list of the event.
    always_comb begin
        lst = '0;
        if (ch_ok) begin
            case (netrw_pkg::t_kind'(i_evt.kind))
                netrw_pkg::K_ON: begin
                    case (i_evt.channel)
                        netrw_pkg::CH_PULSE0, netrw_pkg::CH_PULSE1: begin
                            lst.w[0] = netrw_pkg::f_wr(netrw_pkg::CHIP_BASE,
                                {13'h0800, i_evt.channel[0], 2'd0},
                                {(i_evt.channel[0] ? r_base_duty[3:2] : r_base_duty[1:0]),
                                 2'b11, vol});
                            lst.w[1] = netrw_pkg::f_wr(netrw_pkg::CHIP_BASE,
                                {13'h0800, i_evt.channel[0], 2'd1},
                                i_evt.channel[0] ? r_sweep[15:8] : r_sweep[7:0]);
                            lst.w[2] = netrw_pkg::f_wr(netrw_pkg::CHIP_BASE,
                                {13'h0800, i_evt.channel[0], 2'd2}, base_per[7:0]);
                            lst.w[3] = netrw_pkg::f_wr(netrw_pkg::CHIP_BASE,
                                {13'h0800, i_evt.channel[0], 2'd3},
                                {5'h1F, base_per[10:8]});
                            lst.cnt = 4'd4;
                        end
                        netrw_pkg::CH_TRI: begin
                            lst.w[0] = netrw_pkg::f_wr(netrw_pkg::CHIP_BASE, 16'h4008,
                                                       8'hFF);
                            lst.w[1] = netrw_pkg::f_wr(netrw_pkg::CHIP_BASE, 16'h400A,
                                                       base_per[7:0]);
                            lst.w[2] = netrw_pkg::f_wr(netrw_pkg::CHIP_BASE, 16'h400B,
                                                       {5'h1F, base_per[10:8]});
                            lst.cnt = 4'd3;
                        end
                        netrw_pkg::CH_NOISE: begin
                            lst.w[0] = netrw_pkg::f_wr(netrw_pkg::CHIP_BASE, 16'h400C,
                                                       {4'h3, vol});
                            lst.w[1] = netrw_pkg::f_wr(netrw_pkg::CHIP_BASE, 16'h400E,
                                {r_noise_mode, 3'd0, ~i_evt.note[6:3]});
                            lst.w[2] = netrw_pkg::f_wr(netrw_pkg::CHIP_BASE, 16'h400F,
                                                       8'hF8);
                            lst.cnt = 4'd3;
                        end
                        netrw_pkg::CH_EPULSE0, netrw_pkg::CH_EPULSE1: begin
                            lst.w[0] = netrw_pkg::f_wr(netrw_pkg::CHIP_PULSAW,
                                {i_evt.channel - 4'd5 + 4'h9, 12'h000},
                                {1'b0, (i_evt.channel[0] ? r_exp_duty[2:0]
                                                         : r_exp_duty[5:3]), vol});
                            lst.w[1] = netrw_pkg::f_wr(netrw_pkg::CHIP_PULSAW,
                                {i_evt.channel - 4'd5 + 4'h9, 12'h001}, base_per[7:0]);
                            lst.w[2] = netrw_pkg::f_wr(netrw_pkg::CHIP_PULSAW,
                                {i_evt.channel - 4'd5 + 4'h9, 12'h002},
                                {4'h8, base_per[11:8]});
                            lst.cnt = 4'd3;
                        end
                        netrw_pkg::CH_SAW: begin
                            lst.w[0] = netrw_pkg::f_wr(netrw_pkg::CHIP_PULSAW, 16'hB000,
                                                       {2'd0, saw_rate});
                            lst.w[1] = netrw_pkg::f_wr(netrw_pkg::CHIP_PULSAW, 16'hB001,
                                                       base_per[7:0]);
                            lst.w[2] = netrw_pkg::f_wr(netrw_pkg::CHIP_PULSAW, 16'hB002,
                                                       {4'h8, base_per[11:8]});
                            lst.cnt = 4'd3;
                        end
                        netrw_pkg::CH_SQ0, netrw_pkg::CH_SQ1: begin
                            lst.w[0] = netrw_pkg::f_wr(netrw_pkg::CHIP_SQUARE, 16'h5015,
                                                       8'h03);
                            lst.w[1] = netrw_pkg::f_wr(netrw_pkg::CHIP_SQUARE,
                                {13'h0A00, i_evt.channel[0], 2'd0},
                                {(i_evt.channel[0] ? r_sq_duty[3:2] : r_sq_duty[1:0]),
                                 2'b11, vol});
                            lst.w[2] = netrw_pkg::f_wr(netrw_pkg::CHIP_SQUARE,
                                {13'h0A00, i_evt.channel[0], 2'd2}, base_per[7:0]);
                            lst.w[3] = netrw_pkg::f_wr(netrw_pkg::CHIP_SQUARE,
                                {13'h0A00, i_evt.channel[0], 2'd3},
                                {5'h1F, base_per[10:8]});
                            lst.cnt = 4'd4;
                        end
                        netrw_pkg::CH_TONEA, netrw_pkg::CH_TONEB,
                        netrw_pkg::CH_TONEC: begin
                            lst = f_period(i_evt.channel, rom_tone);
                            lst.w[4] = netrw_pkg::f_wr(netrw_pkg::CHIP_TONE, 16'hC000,
                                                       netrw_pkg::PSG_MIXER);
                            lst.w[5] = netrw_pkg::f_wr(netrw_pkg::CHIP_TONE, 16'hE000,
                                                       {2'd0, n_mask_on});
                            lst.w[6] = netrw_pkg::f_wr(netrw_pkg::CHIP_TONE, 16'hC000,
                                netrw_pkg::PSG_VOL + {6'd0, tidx});
                            lst.w[7] = netrw_pkg::f_wr(netrw_pkg::CHIP_TONE, 16'hE000,
                                                       {4'd0, vol});
                            lst.cnt = 4'd8;
                        end
                        default: lst.cnt = 4'd0;
                    endcase
                end
                netrw_pkg::K_OFF: begin
                    case (i_evt.channel)
                        netrw_pkg::CH_PULSE0, netrw_pkg::CH_PULSE1,
                        netrw_pkg::CH_NOISE: begin
                            lst.w[0] = netrw_pkg::f_wr(netrw_pkg::CHIP_BASE,
                                {12'h400, i_evt.channel[1:0], 2'd0}, 8'h30);
                            lst.cnt = 4'd1;
                        end
                        netrw_pkg::CH_TRI: begin
                            lst.w[0] = netrw_pkg::f_wr(netrw_pkg::CHIP_BASE, 16'h4008,
                                                       8'h80);
                            lst.cnt = 4'd1;
                        end
                        netrw_pkg::CH_EPULSE0, netrw_pkg::CH_EPULSE1,
                        netrw_pkg::CH_SAW: begin
                            lst.w[0] = netrw_pkg::f_wr(netrw_pkg::CHIP_PULSAW,
                                {i_evt.channel - 4'd5 + 4'h9, 12'h002}, 8'h00);
                            lst.cnt = 4'd1;
                        end
                        netrw_pkg::CH_SQ0, netrw_pkg::CH_SQ1: begin
                            // The enable write keeps the other square running.
                            lst.w[0] = netrw_pkg::f_wr(netrw_pkg::CHIP_SQUARE, 16'h5015,
                                {6'd0, ~i_evt.channel[0], i_evt.channel[0]});
                            lst.w[1] = netrw_pkg::f_wr(netrw_pkg::CHIP_SQUARE,
                                {13'h0A00, i_evt.channel[0], 2'd0}, 8'h30);
                            lst.cnt = 4'd2;
                        end
                        netrw_pkg::CH_TONEA, netrw_pkg::CH_TONEB,
                        netrw_pkg::CH_TONEC: begin
                            lst.w[0] = netrw_pkg::f_wr(netrw_pkg::CHIP_TONE, 16'hC000,
                                netrw_pkg::PSG_VOL + {6'd0, tidx});
                            lst.w[1] = netrw_pkg::f_wr(netrw_pkg::CHIP_TONE, 16'hE000,
                                                       8'h00);
                            lst.w[2] = netrw_pkg::f_wr(netrw_pkg::CHIP_TONE, 16'hC000,
                                                       netrw_pkg::PSG_MIXER);
                            lst.w[3] = netrw_pkg::f_wr(netrw_pkg::CHIP_TONE, 16'hE000,
                                                       {2'd0, n_mask_off});
                            lst.cnt = 4'd4;
                        end
                        default: lst.cnt = 4'd0;
                    endcase
                end
                netrw_pkg::K_CHANGE: lst = f_period(i_evt.channel, per);
                netrw_pkg::K_PITCH: begin
                    if (!cur_note[7]) begin
                        lst = f_period(i_evt.channel, adj_c);
                    end
                end
                netrw_pkg::K_VOLUME: begin
                    case (i_evt.channel)
                        netrw_pkg::CH_PULSE0, netrw_pkg::CH_PULSE1: begin
                            lst.w[0] = netrw_pkg::f_wr(netrw_pkg::CHIP_BASE,
                                {13'h0800, i_evt.channel[0], 2'd0},
                                {(i_evt.channel[0] ? r_base_duty[3:2] : r_base_duty[1:0]),
                                 2'b11, mvol});
                            lst.cnt = 4'd1;
                        end
                        netrw_pkg::CH_NOISE: begin
                            lst.w[0] = netrw_pkg::f_wr(netrw_pkg::CHIP_BASE, 16'h400C,
                                                       {4'h3, mvol});
                            lst.cnt = 4'd1;
                        end
                        netrw_pkg::CH_EPULSE0, netrw_pkg::CH_EPULSE1: begin
                            lst.w[0] = netrw_pkg::f_wr(netrw_pkg::CHIP_PULSAW,
                                {i_evt.channel - 4'd5 + 4'h9, 12'h000},
                                {1'b0, (i_evt.channel[0] ? r_exp_duty[2:0]
                                                         : r_exp_duty[5:3]), mvol});
                            lst.cnt = 4'd1;
                        end
                        netrw_pkg::CH_SAW: begin
                            lst.w[0] = netrw_pkg::f_wr(netrw_pkg::CHIP_PULSAW, 16'hB000,
                                                       {2'd0, f_saw(mvol)});
                            lst.cnt = 4'd1;
                        end
                        netrw_pkg::CH_SQ0, netrw_pkg::CH_SQ1: begin
                            lst.w[0] = netrw_pkg::f_wr(netrw_pkg::CHIP_SQUARE,
                                {13'h0A00, i_evt.channel[0], 2'd0},
                                {(i_evt.channel[0] ? r_sq_duty[3:2] : r_sq_duty[1:0]),
                                 2'b11, mvol});
                            lst.cnt = 4'd1;
                        end
                        netrw_pkg::CH_TONEA, netrw_pkg::CH_TONEB,
                        netrw_pkg::CH_TONEC: begin
                            lst.w[0] = netrw_pkg::f_wr(netrw_pkg::CHIP_TONE, 16'hC000,
                                netrw_pkg::PSG_VOL + {6'd0, tidx});
                            lst.w[1] = netrw_pkg::f_wr(netrw_pkg::CHIP_TONE, 16'hE000,
                                                       {4'd0, mvol});
                            lst.cnt = 4'd2;
                        end
                        default: lst.cnt = 4'd0;
                    endcase
                end
                netrw_pkg::K_DUTY: begin
                    case (i_evt.channel)
                        netrw_pkg::CH_PULSE0, netrw_pkg::CH_PULSE1: begin
                            lst.w[0] = netrw_pkg::f_wr(netrw_pkg::CHIP_BASE,
                                {13'h0800, i_evt.channel[0], 2'd0}, duty_byte);
                            lst.cnt = 4'd1;
                        end
                        netrw_pkg::CH_SQ0, netrw_pkg::CH_SQ1: begin
                            lst.w[0] = netrw_pkg::f_wr(netrw_pkg::CHIP_SQUARE,
                                {13'h0A00, i_evt.channel[0], 2'd0}, duty_byte);
                            lst.cnt = 4'd1;
                        end
                        default: lst.cnt = 4'd0;
                    endcase
                end
                default: lst.cnt = 4'd0;
            endcase
        end
    end

    assign o_push = accept && (lst.cnt != 4'd0);
    assign o_list = lst;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_duty  <= '0;
            r_sweep      <= '0;
            r_noise_mode <= 1'b0;
            r_exp_duty   <= '0;
            r_sq_duty    <= '0;
        end else if (i_cfg.valid) begin
            case (netrw_pkg::t_reg'(i_cfg.index))
                netrw_pkg::REG_BASE_DUTY:  r_base_duty  <= i_cfg.data[3:0];
                netrw_pkg::REG_SWEEP:      r_sweep      <= i_cfg.data;
                netrw_pkg::REG_NOISE_MODE: r_noise_mode <= i_cfg.data[0];
                netrw_pkg::REG_EXP_DUTY:   r_exp_duty   <= i_cfg.data[5:0];
                netrw_pkg::REG_SQ_DUTY:    r_sq_duty    <= i_cfg.data[3:0];
                default: ;
            endcase
        end
    end

    // Current notes and tone mixer mask, updated by note on and note off.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < netrw_pkg::NUM_CH; c++) begin
                r_notes[c] <= netrw_pkg::NO_NOTE;
            end
            r_mask <= netrw_pkg::MASK_RESET;
        end else if (accept && ch_ok) begin
            case (netrw_pkg::t_kind'(i_evt.kind))
                netrw_pkg::K_ON: begin
                    r_notes[i_evt.channel] <= {1'b0, i_evt.note};
                    if (i_evt.channel >= netrw_pkg::CH_TONEA) begin
                        r_mask <= n_mask_on;
                    end
                end
                netrw_pkg::K_OFF: begin
                    r_notes[i_evt.channel] <= netrw_pkg::NO_NOTE;
                    if (i_evt.channel >= netrw_pkg::CH_TONEA) begin
                        r_mask <= n_mask_off;
                    end
                end
                default: ;
            endcase
        end
    end

    // Only the three tone bits of the mixer mask ever clear.
    a_mask_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mask[5:3] == 3'b111)
        else $error("tone mixer mask upper bits cleared");

endmodule
`default_nettype wire

[hdl/netrw_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// netrw_queue: event write-list queue
// Short FIFO of write lists between the classifier and the write sequencer.
// ----------------------------------------------------------------------------
module netrw_queue #(
    parameter int DEPTH = netrw_pkg::QUEUE_DEPTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire netrw_pkg::t_list i_list,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_valid,
    output netrw_pkg::t_list      o_list
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    netrw_pkg::t_list r_mem [DEPTH];
    logic [PW-1:0]    r_wp, r_rp;
    logic [CW-1:0]    r_cnt;

    assign o_full  = r_cnt == CW'(DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_list  = r_mem[r_rp];

    // Storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_list;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + CW'(i_push) - CW'(i_pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");

endmodule
`default_nettype wire

[hdl/netrw_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// netrw_back: write sequencer
// Walks the head write list one write per beat into the output register and
// marks the final write of each event.
// ----------------------------------------------------------------------------
module netrw_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire netrw_pkg::t_list i_list,
    output logic                  o_pop,
    netrw_wr_if.source            o_wr
);

    logic          r_valid;
    netrw_pkg::t_wr r_wr;
    logic          r_last;
    logic [2:0]    r_idx;

    logic          load;
    logic          is_last;
    netrw_pkg::t_wr cur;

    assign load    = !r_valid || o_wr.ready;
    assign cur     = i_list.w[r_idx];
    assign is_last = {1'b0, r_idx} == (i_list.cnt - 4'd1);
    assign o_pop   = load && i_valid && is_last;

    // Output register and position within the head list.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (load) begin
            r_valid <= i_valid;
            if (i_valid) begin
                r_idx <= is_last ? 3'd0 : r_idx + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_valid) begin
            r_wr   <= cur;
            r_last <= is_last;
        end
    end

    assign o_wr.valid       = r_valid;
    assign o_wr.target_chip = r_wr.chip;
    assign o_wr.address     = r_wr.addr;
    assign o_wr.data        = r_wr.data;
    assign o_wr.last        = r_last;

    a_list_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (i_list.cnt != 4'd0 && {1'b0, r_idx} < i_list.cnt))
        else $error("write index beyond head list");

endmodule
`default_nettype wire

[hdl/note_event_to_register_writes.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// note_event_to_register_writes: note events to tagged register writes
// Translates note and macro events for 13 sound channels into ordered,
// chip-tagged register writes.
// ----------------------------------------------------------------------------
// An event beat is taken whenever the write-list queue has room; its writes
// then leave one per cycle while the output is ready, so the sustained rate is
// set by the output sequencer at one write per cycle, with one to eight writes
// per event. Events that cause no writes are still taken at the input. The
// first write of an event passes through the queue and then the sequencer's
// output register. Configuration writes are taken every cycle and must arrive
// while the block is idle.
module note_event_to_register_writes #(
    parameter int QUEUE_DEPTH = netrw_pkg::QUEUE_DEPTH
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    netrw_cfg_if.sink i_cfg,
    netrw_evt_if.sink i_evt,
    netrw_wr_if.source o_wr
);

    logic             push, full, q_valid, pop;
    netrw_pkg::t_list push_list, head_list;

    netrw_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_evt    (i_evt),
        .i_cfg    (i_cfg),
        .i_q_full (full),
        .o_push   (push),
        .o_list   (push_list)
    );

    netrw_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_list  (push_list),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_list  (head_list)
    );

    netrw_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_list  (head_list),
        .o_pop   (pop),
        .o_wr    (o_wr)
    );

endmodule
`default_nettype wire
